// ----- src/aabb_affine_transform_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the AABB affine transform block
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// Checked only outside reset.
`define AAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define AAT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/aat_pkg.sv -----
// ----------------------------------------------------------------------------
// aat_pkg
// Types, widths and rounding helper for the AABB affine transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 12;
  localparam int FIELD_BITS = 60;
  localparam int N_AXES     = 3;
  localparam int N_STAGES   = 4;

  localparam int S_DATA_W = 6 * FIELD_BITS;
  localparam int M_DATA_W = 2 * FIELD_BITS;

  // Product of two lanes, cofactor, determinant term, determinant sum.
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int COF_W  = PROD_W + 1;
  localparam int DT_W   = COF_W + COORD_BITS;
  localparam int DET_W  = DT_W + 2;
  // Translation scaled plus three products.
  localparam int SUM_W  = PROD_W + 3;

  typedef logic signed [COORD_BITS-1:0] lane_t;
  typedef lane_t [N_AXES-1:0] vec_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Per-stage load enables from the top-level flow control.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } pipe_ctl_t;

  localparam sum_t HALF     = SUM_W'((1 << FRAC_BITS) >> 1);
  localparam sum_t LANE_MAX = SUM_W'((1 << (COORD_BITS - 1)) - 1);
  localparam sum_t LANE_MIN = -LANE_MAX - SUM_W'(1);

  // Round to nearest, ties toward +inf, then clamp to the lane range.
  function automatic lane_t round_sat(input sum_t wide);
    sum_t r;
    r = (wide + HALF) >>> FRAC_BITS;
    if (r > LANE_MAX) begin
      r = LANE_MAX;
    end else if (r < LANE_MIN) begin
      r = LANE_MIN;
    end
    return r[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/aat_axis.sv -----
// ----------------------------------------------------------------------------
// aat_axis
// One world axis: six corner products, min/max pick, sum, round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_axis (
  input  wire logic              clk,
  input  wire aat_pkg::pipe_ctl_t ctl,
  input  wire aat_pkg::vec_t     mat_row,   // matrix entry of this axis, by column
  input  wire aat_pkg::vec_t     lo,
  input  wire aat_pkg::vec_t     hi,
  input  wire aat_pkg::lane_t    tr,
  input  wire logic              has_mesh,
  output aat_pkg::lane_t         wmin,
  output aat_pkg::lane_t         wmax
);

  // stage 1: products
  aat_pkg::prod_t p1 [aat_pkg::N_AXES];
  aat_pkg::prod_t q1 [aat_pkg::N_AXES];
  aat_pkg::lane_t tr1;
  logic           mesh1;

  // stage 2: ordered pairs
  aat_pkg::prod_t lo2 [aat_pkg::N_AXES];
  aat_pkg::prod_t hi2 [aat_pkg::N_AXES];
  aat_pkg::lane_t tr2;
  logic           mesh2;

  // stage 3: exact sums
  aat_pkg::sum_t  lower3;
  aat_pkg::sum_t  upper3;
  aat_pkg::lane_t tr3;
  logic           mesh3;

  aat_pkg::sum_t  tr_scaled;

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      for (int c = 0; c < aat_pkg::N_AXES; c++) begin
        p1[c] <= mat_row[c] * lo[c];
        q1[c] <= mat_row[c] * hi[c];
      end
      tr1   <= tr;
      mesh1 <= has_mesh;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      for (int c = 0; c < aat_pkg::N_AXES; c++) begin
        lo2[c] <= (p1[c] < q1[c]) ? p1[c] : q1[c];
        hi2[c] <= (p1[c] < q1[c]) ? q1[c] : p1[c];
      end
      tr2   <= tr1;
      mesh2 <= mesh1;
    end
  end

  assign tr_scaled = aat_pkg::sum_t'(tr2) <<< aat_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      lower3 <= tr_scaled + aat_pkg::sum_t'(lo2[0]) + aat_pkg::sum_t'(lo2[1])
              + aat_pkg::sum_t'(lo2[2]);
      upper3 <= tr_scaled + aat_pkg::sum_t'(hi2[0]) + aat_pkg::sum_t'(hi2[1])
              + aat_pkg::sum_t'(hi2[2]);
      tr3    <= tr2;
      mesh3  <= mesh2;
    end
  end

  // No mesh: the box collapses to the translation point.
  always_ff @(posedge clk) begin
    if (ctl.s4_en) begin
      wmin <= mesh3 ? aat_pkg::round_sat(lower3) : tr3;
      wmax <= mesh3 ? aat_pkg::round_sat(upper3) : tr3;
    end
  end

endmodule

`default_nettype wire

// ----- src/aat_det.sv -----
// ----------------------------------------------------------------------------
// aat_det
// Exact 3x3 determinant of the linear part, reported as its sign bit.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_det (
  input  wire logic               clk,
  input  wire aat_pkg::pipe_ctl_t ctl,
  input  wire aat_pkg::vec_t      col [aat_pkg::N_AXES],  // col[c][axis]
  output logic                    negative
);

  localparam int CW = aat_pkg::COF_W;
  localparam int TW = aat_pkg::DT_W;
  localparam int DW = aat_pkg::DET_W;

  // stage 1: 2x2 minor products, first-row entries carried along
  aat_pkg::prod_t a1, b1, c1, d1, e1, f1;
  aat_pkg::vec_t  top1;

  // stage 2: cofactors
  logic signed [CW-1:0] cof2 [aat_pkg::N_AXES];
  aat_pkg::vec_t        top2;

  // stage 3: expansion terms
  logic signed [TW-1:0] term3 [aat_pkg::N_AXES];

  logic signed [DW-1:0] det_sum;

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      a1 <= col[1][1] * col[2][2];
      b1 <= col[2][1] * col[1][2];
      c1 <= col[0][1] * col[2][2];
      d1 <= col[2][1] * col[0][2];
      e1 <= col[0][1] * col[1][2];
      f1 <= col[1][1] * col[0][2];
      for (int c = 0; c < aat_pkg::N_AXES; c++) begin
        top1[c] <= col[c][0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      cof2[0] <= CW'(a1) - CW'(b1);
      cof2[1] <= CW'(c1) - CW'(d1);
      cof2[2] <= CW'(e1) - CW'(f1);
      top2    <= top1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_en) begin
      for (int c = 0; c < aat_pkg::N_AXES; c++) begin
        term3[c] <= top2[c] * cof2[c];
      end
    end
  end

  // middle column enters with a minus sign
  assign det_sum = DW'(term3[0]) - DW'(term3[1]) + DW'(term3[2]);

  always_ff @(posedge clk) begin
    if (ctl.s4_en) begin
      negative <= det_sum[DW-1];
    end
  end

endmodule

`default_nettype wire

// ----- src/aabb_affine_transform.sv -----
// ----------------------------------------------------------------------------
// aabb_affine_transform
// World bounding box of an affinely transformed local box, plus winding flag.
// ----------------------------------------------------------------------------
// Input stream (s_*): one request per box carries the three linear columns,
// the translation and the local min/max corners in s_tdata; s_tuser holds
// has_mesh. Output stream (m_*): world min/max corners in m_tdata, the
// reverse-culling flag in m_tuser.
// An accepted request passes through the stages to m_tvalid: products,
// min/max pick and cofactors, exact sums and determinant terms, then
// rounding, clamping and the determinant sign. The 4-stage pipeline takes
// one request per cycle while m_tready keeps the output draining; each
// stage is bound by one 20x20 or 41x20 multiply or one wide add.
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and
// s_tready drops only once all four stages hold results. Nothing is lost or
// repeated across a stall.
// Reset (rst, synchronous) clears the valid bits; the pipeline is empty and
// ready on the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_affine_transform (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // column_x, column_y, column_z, translation, local_min, local_max
  input  wire logic [aat_pkg::S_DATA_W-1:0]  s_tdata,
  // has_mesh
  input  wire logic [0:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // world_min, world_max
  output logic [aat_pkg::M_DATA_W-1:0]       m_tdata,
  // reverse_culling
  output logic [0:0]                         m_tuser
);

  localparam int CB = aat_pkg::COORD_BITS;
  localparam int FB = aat_pkg::FIELD_BITS;
  localparam int NA = aat_pkg::N_AXES;
  localparam int NS = aat_pkg::N_STAGES;

  // Field positions in s_tdata.
  localparam int TR_FIELD = 3;
  localparam int LO_FIELD = 4;
  localparam int HI_FIELD = 5;

  logic [NS-1:0]      vld;
  logic [NS-1:0]      rdy;
  aat_pkg::pipe_ctl_t ctl;

  aat_pkg::vec_t col [NA];
  aat_pkg::vec_t mat_row [NA];
  aat_pkg::vec_t tr, lo, hi;
  aat_pkg::vec_t wmin_lane, wmax_lane;
  logic [FB-1:0] world_min, world_max;
  logic          reverse_culling;

  // ready ripples back from the output: a stage loads when empty or draining
  always_comb begin
    rdy[NS-1] = !vld[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign ctl.s1_en = rdy[0];
  assign ctl.s2_en = rdy[1];
  assign ctl.s3_en = rdy[2];
  assign ctl.s4_en = rdy[3];

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      for (int c = 0; c < NA; c++) begin
        col[c][a]     = s_tdata[c*FB + a*CB +: CB];
        mat_row[a][c] = s_tdata[c*FB + a*CB +: CB];
      end
      tr[a] = s_tdata[TR_FIELD*FB + a*CB +: CB];
      lo[a] = s_tdata[LO_FIELD*FB + a*CB +: CB];
      hi[a] = s_tdata[HI_FIELD*FB + a*CB +: CB];
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_axis
    aat_axis u_axis (
      .clk      (clk),
      .ctl      (ctl),
      .mat_row  (mat_row[a]),
      .lo       (lo),
      .hi       (hi),
      .tr       (tr[a]),
      .has_mesh (s_tuser[0]),
      .wmin     (wmin_lane[a]),
      .wmax     (wmax_lane[a])
    );
  end

  aat_det u_det (
    .clk      (clk),
    .ctl      (ctl),
    .col      (col),
    .negative (reverse_culling)
  );

  always_comb begin
    world_min = '0;
    world_max = '0;
    for (int a = 0; a < NA; a++) begin
      world_min[a*CB +: CB] = wmin_lane[a];
      world_max[a*CB +: CB] = wmax_lane[a];
    end
  end

  assign m_tdata = {world_max, world_min};
  assign m_tuser = reverse_culling;

endmodule

`default_nettype wire

// ----- src/aat_checker.sv -----
// ----------------------------------------------------------------------------
// aat_checker
// Port-level checks on flow control and latency of the transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aabb_affine_transform_assert.svh"

module aat_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [aat_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [0:0]                   m_tuser
);

  logic s_acc;

  assign s_acc = s_tvalid && s_tready;

  `AAT_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !m_tvalid, "output valid right after reset")

  `AAT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // a free output means every stage can move, so the input is open
  `AAT_ASSERT(a_ready_follows, m_tready |-> s_tready, "input blocked while output is free")

  // with no back-pressure an accepted request comes out at the output
  `AAT_ASSERT(a_latency, s_acc ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid, "request did not arrive after four cycles")

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (.*);

`default_nettype wire

// ----- tb/tb_aabb_affine_transform.sv -----
// ----------------------------------------------------------------------------
// tb_aabb_affine_transform
// Self-checking bench for the world bounding box / winding flag pipeline.
// ----------------------------------------------------------------------------
// Drives boxes with their affine transforms on the input stream. A behavioral
// predictor computes the world box corners with exact products, a single
// rounding step (half toward +inf) and lane clamping, plus the sign of the
// 3x3 determinant. Each returned box is checked against the oldest pending
// prediction. Directed cases cover lane extremes, the no-mesh pass-through,
// swapped corners, rounding ties, clamping and singular or mirrored matrices.
// Random traffic follows, with random gaps and stalls on both sides and one
// stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_aabb_affine_transform;

  localparam longint LANE_HI = (longint'(1) << (aat_pkg::COORD_BITS - 1)) - 1;
  localparam longint LANE_LO = -(longint'(1) << (aat_pkg::COORD_BITS - 1));
  localparam int IDLE_PCT = 34;

  typedef enum {LANE_FULL, LANE_SMALL, LANE_EDGE} lane_kind_t;

  typedef struct {
    aat_pkg::vec_t cx, cy, cz, tr, lmin, lmax;
    bit            mesh;
  } box_req_t;

  typedef struct {
    aat_pkg::vec_t wmin, wmax;
    bit            mirrored;
  } world_box_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  // column_x, column_y, column_z, translation, local_min, local_max
  logic [aat_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic [0:0]                   s_tuser = '0;  // has_mesh
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [aat_pkg::M_DATA_W-1:0] m_tdata;       // world_min, world_max
  logic [0:0]                   m_tuser;       // reverse_culling

  world_box_t pending_world_boxes[$];
  world_box_t want_box;
  bit         quiet_link = 1'b0;
  int         error_count = 0;
  int         boxes_sent = 0;
  int         boxes_checked = 0;
  int         mirrored_seen = 0;
  int         flat_boxes = 0;

  aabb_affine_transform uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic aat_pkg::lane_t round_clamp(input longint wide);
    longint half;
    longint r;
    half = (longint'(1) << aat_pkg::FRAC_BITS) >> 1;
    r = (wide + half) >>> aat_pkg::FRAC_BITS;  // floor of the shifted sum
    if (r > LANE_HI) begin
      r = LANE_HI;
    end else if (r < LANE_LO) begin
      r = LANE_LO;
    end
    return aat_pkg::lane_t'(r);
  endfunction

  function automatic world_box_t predict_world_box(input box_req_t b);
    world_box_t    res;
    aat_pkg::vec_t col[3];
    longint        m[3][3];
    longint        lo, hi, p, q, det;
    col[0] = b.cx;
    col[1] = b.cy;
    col[2] = b.cz;
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 3; a++) begin
        m[c][a] = longint'(col[c][a]);
      end
    end
    for (int a = 0; a < 3; a++) begin
      if (b.mesh) begin
        lo = longint'(b.tr[a]) <<< aat_pkg::FRAC_BITS;
        hi = lo;
        for (int c = 0; c < 3; c++) begin
          p = m[c][a] * longint'(b.lmin[c]);
          q = m[c][a] * longint'(b.lmax[c]);
          lo += (p < q) ? p : q;
          hi += (p < q) ? q : p;
        end
        res.wmin[a] = round_clamp(lo);
        res.wmax[a] = round_clamp(hi);
      end else begin
        res.wmin[a] = b.tr[a];
        res.wmax[a] = b.tr[a];
      end
    end
    det = m[0][0] * (m[1][1] * m[2][2] - m[2][1] * m[1][2])
        - m[1][0] * (m[0][1] * m[2][2] - m[2][1] * m[0][2])
        + m[2][0] * (m[0][1] * m[1][2] - m[1][1] * m[0][2]);
    res.mirrored = (det < 0);
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic aat_pkg::vec_t vec3(input longint x, input longint y, input longint z);
    aat_pkg::vec_t v;
    v[0] = aat_pkg::lane_t'(x);
    v[1] = aat_pkg::lane_t'(y);
    v[2] = aat_pkg::lane_t'(z);
    return v;
  endfunction

  function automatic box_req_t mk_box(input aat_pkg::vec_t cx, input aat_pkg::vec_t cy,
                                      input aat_pkg::vec_t cz, input aat_pkg::vec_t tr,
                                      input aat_pkg::vec_t lmin, input aat_pkg::vec_t lmax,
                                      input bit mesh);
    box_req_t b;
    b.cx = cx;
    b.cy = cy;
    b.cz = cz;
    b.tr = tr;
    b.lmin = lmin;
    b.lmax = lmax;
    b.mesh = mesh;
    return b;
  endfunction

  function automatic aat_pkg::lane_t rand_lane(input lane_kind_t kind);
    aat_pkg::lane_t v;
    case (kind)
      LANE_FULL: begin
        v = aat_pkg::lane_t'($urandom);
      end
      LANE_SMALL: begin
        // within about +-2.0, the usual range of rotation/scale entries
        v = aat_pkg::lane_t'(int'($urandom_range(0, 16383)) - 8192);
      end
      default: begin
        case ($urandom_range(0, 7))
          0: v = aat_pkg::lane_t'(LANE_HI);
          1: v = aat_pkg::lane_t'(LANE_LO);
          2: v = '0;
          3: v = aat_pkg::lane_t'(1);
          4: v = aat_pkg::lane_t'(-1);
          5: v = aat_pkg::lane_t'(1 << aat_pkg::FRAC_BITS);
          6: v = aat_pkg::lane_t'(-(1 << aat_pkg::FRAC_BITS));
          default: v = aat_pkg::lane_t'(1 << (aat_pkg::FRAC_BITS - 1));
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic aat_pkg::vec_t rand_vec(input lane_kind_t kind);
    aat_pkg::vec_t v;
    for (int a = 0; a < 3; a++) begin
      v[a] = rand_lane(kind);
    end
    return v;
  endfunction

  function automatic lane_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return LANE_FULL;
    end else if (r < 80) begin
      return LANE_SMALL;
    end
    return LANE_EDGE;
  endfunction

  function automatic box_req_t rand_box();
    box_req_t   b;
    lane_kind_t k;
    k = pick_kind();
    b.cx = rand_vec(k);
    b.cy = rand_vec(k);
    b.cz = rand_vec(k);
    // some items reuse a column so singular matrices show up now and then
    if ($urandom_range(0, 19) == 0) begin
      b.cz = b.cx;
    end
    b.tr = rand_vec(pick_kind());
    k = pick_kind();
    b.lmin = rand_vec(k);
    b.lmax = rand_vec(k);
    b.mesh = ($urandom_range(0, 99) < 85);
    return b;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_box(input box_req_t b);
    world_box_t predicted;
    while (!quiet_link && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b.lmax, b.lmin, b.tr, b.cz, b.cy, b.cx};
    s_tuser  <= b.mesh;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    predicted = predict_world_box(b);
    pending_world_boxes = {pending_world_boxes, predicted};
    boxes_sent++;
    if (!b.mesh) begin
      flat_boxes++;
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (quiet_link) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("[%0t] box %0d %s: got %h, want %h", $realtime, boxes_checked, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_world_boxes.size() == 0) begin
        report_mismatch("unexpected result", {4'h0, m_tdata[aat_pkg::FIELD_BITS-1:0]}, '0);
      end else begin
        want_box = pending_world_boxes.pop_front();
        if (m_tdata[aat_pkg::FIELD_BITS-1:0] !== want_box.wmin) begin
          report_mismatch("world_min", {4'h0, m_tdata[aat_pkg::FIELD_BITS-1:0]},
                          {4'h0, want_box.wmin});
        end
        if (m_tdata[2*aat_pkg::FIELD_BITS-1:aat_pkg::FIELD_BITS] !== want_box.wmax) begin
          report_mismatch("world_max",
                          {4'h0, m_tdata[2*aat_pkg::FIELD_BITS-1:aat_pkg::FIELD_BITS]},
                          {4'h0, want_box.wmax});
        end
        if (m_tuser[0] !== want_box.mirrored) begin
          report_mismatch("reverse_culling", {63'b0, m_tuser}, {63'b0, want_box.mirrored});
        end
        if (want_box.mirrored) begin
          mirrored_seen++;
        end
      end
      boxes_checked++;
    end
  end

  // ---------------------------------------------------------------- tests

  localparam longint ONE = longint'(1) << aat_pkg::FRAC_BITS;

  task automatic test_identity_and_zero();
    send_box(mk_box('0, '0, '0, '0, '0, '0, 1'b1));
    send_box(mk_box(vec3(ONE, 0, 0), vec3(0, ONE, 0), vec3(0, 0, ONE),
                    vec3(3 * ONE, -5 * ONE, 77), vec3(-ONE, -2 * ONE, -3),
                    vec3(ONE, 2 * ONE, 3), 1'b1));
  endtask

  task automatic test_lane_extremes();
    aat_pkg::vec_t hi_v, lo_v, ones, alt_a, alt_b;
    hi_v  = vec3(LANE_HI, LANE_HI, LANE_HI);
    lo_v  = vec3(LANE_LO, LANE_LO, LANE_LO);
    ones  = '1;
    alt_a = aat_pkg::vec_t'(60'h5555_5555_5555_555);
    alt_b = aat_pkg::vec_t'(60'hAAAA_AAAA_AAAA_AAA);
    send_box(mk_box(hi_v, hi_v, hi_v, hi_v, lo_v, hi_v, 1'b1));
    send_box(mk_box(lo_v, lo_v, lo_v, lo_v, lo_v, hi_v, 1'b1));
    send_box(mk_box(hi_v, lo_v, hi_v, lo_v, hi_v, lo_v, 1'b1));
    send_box(mk_box(ones, ones, ones, ones, ones, ones, 1'b1));
    send_box(mk_box(alt_a, alt_b, alt_a, alt_b, alt_a, alt_b, 1'b1));
    send_box(mk_box(alt_b, alt_a, alt_b, alt_a, alt_b, alt_a, 1'b1));
  endtask

  task automatic test_no_mesh();
    // flag still comes from the (mirrored) matrix
    send_box(mk_box(vec3(-ONE, 0, 0), vec3(0, ONE, 0), vec3(0, 0, ONE),
                    vec3(LANE_HI, LANE_LO, -1), vec3(LANE_HI, 0, 0),
                    vec3(LANE_LO, 0, 0), 1'b0));
    send_box(mk_box('1, '1, '1, vec3(0, 1, LANE_LO), '1, '0, 1'b0));
  endtask

  task automatic test_swapped_corners();
    send_box(mk_box(vec3(ONE, ONE / 2, -ONE), vec3(-ONE, ONE, 3), vec3(7, -9, ONE),
                    vec3(100, -100, 0), vec3(5 * ONE, -ONE, 2 * ONE),
                    vec3(-5 * ONE, ONE, -2 * ONE), 1'b1));
    send_box(mk_box(vec3(ONE, 0, 0), vec3(0, ONE, 0), vec3(0, 0, -ONE),
                    '0, vec3(LANE_HI, LANE_HI, LANE_HI), vec3(LANE_LO, LANE_LO, LANE_LO),
                    1'b1));
  endtask

  task automatic test_rounding_ties();
    // exact half-LSB sums: both signs round toward +inf
    send_box(mk_box(vec3(1, 0, 0), '0, '0, '0, vec3(ONE / 2, 0, 0),
                    vec3(ONE / 2, 0, 0), 1'b1));
    send_box(mk_box(vec3(1, 0, 0), '0, '0, '0, vec3(-ONE / 2, 0, 0),
                    vec3(-ONE / 2, 0, 0), 1'b1));
    send_box(mk_box(vec3(1, 1, 1), '0, '0, vec3(-3, 4, 0),
                    vec3(-3 * ONE / 2, ONE / 2 - 1, ONE / 2 + 1),
                    vec3(3 * ONE / 2, ONE / 2, -ONE / 2), 1'b1));
  endtask

  task automatic test_clamping();
    // translation at the edge pushed further out by a small product
    send_box(mk_box(vec3(ONE, ONE, ONE), '0, '0, vec3(LANE_HI, LANE_LO, LANE_HI - 1),
                    vec3(-2, -2, -2), vec3(2, 2, 2), 1'b1));
    send_box(mk_box(vec3(LANE_HI, LANE_LO, 0), vec3(LANE_LO, LANE_HI, 0),
                    vec3(0, 0, LANE_HI), vec3(LANE_HI, LANE_LO, 0),
                    vec3(LANE_LO, LANE_LO, LANE_LO), vec3(LANE_HI, LANE_HI, LANE_HI), 1'b1));
  endtask

  task automatic test_determinant_sign();
    aat_pkg::vec_t box_lo, box_hi;
    box_lo = vec3(-ONE, -ONE, -ONE);
    box_hi = vec3(ONE, ONE, ONE);
    send_box(mk_box(vec3(0, ONE, 0), vec3(ONE, 0, 0), vec3(0, 0, ONE),
                    '0, box_lo, box_hi, 1'b1));
    // repeated column: zero determinant
    send_box(mk_box(vec3(ONE, 2, 3), vec3(ONE, 2, 3), vec3(0, 0, ONE),
                    '0, box_lo, box_hi, 1'b1));
    // rank one, non-trivial entries
    send_box(mk_box(vec3(2, 4, 6), vec3(-1, -2, -3), vec3(3, 6, 9),
                    '0, box_lo, box_hi, 1'b1));
    // largest magnitude, negative
    send_box(mk_box(vec3(LANE_LO, 0, 0), vec3(0, LANE_HI, 0), vec3(0, 0, LANE_HI),
                    '0, box_lo, box_hi, 1'b1));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      send_box(rand_box());
    end
  endtask

  task automatic test_full_rate_burst(input int count);
    quiet_link = 1'b1;
    test_random_traffic(count);
    quiet_link = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_identity_and_zero();
    test_lane_extremes();
    test_no_mesh();
    test_swapped_corners();
    test_rounding_ties();
    test_clamping();
    test_determinant_sign();
    test_random_traffic(700);
    test_full_rate_burst(450);
    test_random_traffic(680);

    s_tvalid <= 1'b0;
    while (pending_world_boxes.size() != 0) begin
      @(posedge clk);
    end
    repeat (3 * aat_pkg::N_STAGES) @(posedge clk);

    $display("%0d boxes sent, %0d results checked (%0d mirrored, %0d without mesh),",
             boxes_sent, boxes_checked, mirrored_seen, flat_boxes);
    $display("random gaps and stalls on both streams plus one full-rate burst.");
    if (error_count == 0 && boxes_checked == boxes_sent) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_world_boxes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
